// File: sv/lav_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants, sideband types and rounding helpers for the
// look-at view matrix core. No dependencies.
package lav_pkg;

   localparam int COORD_W      = 32;  // Q16.16 coordinate
   localparam int FRAC_W       = 16;
   localparam int HALF_Q       = 32768;
   localparam int ONE_Q        = 65536;
   localparam int SHORT_SQ_MAX = 42;  // 0.0001 squared, in LSB units
   localparam int NEAR_MAX     = 7;   // bound on each component in the short test
   localparam int NEAR_W       = 3;

   localparam int IN_W   = 33;  // signed vector component into a normalizer
   localparam int MAG_W  = 33;  // its magnitude
   localparam int NRM_W  = 31;  // prescaled magnitude, top bit at NRM_TOP
   localparam int NRM_TOP = 30;
   localparam int POS_W  = 6;
   localparam int SQ_W   = 64;  // sum of squares
   localparam int LEN_W  = 32;  // vector length
   localparam int NUM_W  = 48;  // dividend
   localparam int QUO_W  = 18;  // quotient magnitude
   localparam int VEC_W  = 19;  // signed unit-vector component
   localparam int UVEC_W = 20;  // signed recomputed up component
   localparam int PROD_W = 38;  // unit x unit product
   localparam int CRS_W  = 40;  // cross product sum
   localparam int RE_W   = 51;  // unit x coordinate product
   localparam int UE_W   = 52;  // up x coordinate product
   localparam int DOT_W  = 54;  // dot product sum

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [VEC_W-1:0]   vec_type;
   typedef logic signed [UVEC_W-1:0]  uvec_type;

   typedef struct packed {
      logic                         short_fwd;
      logic [2:0][COORD_W-1:0]      eye;
   } fwd_side_type;

   typedef struct packed {
      logic                         norm;
      logic [2:0][VEC_W-1:0]        fwd;
      logic [2:0][COORD_W-1:0]      eye;
   } rgt_side_type;

   // Round half up (toward +inf) from Q32 to Q16.16, narrow result.
   function automatic uvec_type round_cross(input logic signed [CRS_W-1:0] v);
      logic signed [CRS_W-1:0] t;
      t = v + CRS_W'(HALF_Q);
      return t[UVEC_W+FRAC_W-1:FRAC_W];
   endfunction

   // Round half up from Q32 to Q16.16 and clamp to the 32-bit range.
   function automatic coord_type round_sat(input logic signed [DOT_W-1:0] v);
      logic signed [DOT_W-1:0] t;
      logic [DOT_W-FRAC_W-1:0] s;
      coord_type               r;
      t = v + DOT_W'(HALF_Q);
      s = t[DOT_W-1:FRAC_W];
      if ((&s[DOT_W-FRAC_W-1:COORD_W-1]) || !(|s[DOT_W-FRAC_W-1:COORD_W-1])) begin
         r = s[COORD_W-1:0];
      end else if (s[DOT_W-FRAC_W-1]) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: sv/lav_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for point-pair requests and matrix responses.
// Depends on lav_pkg.
interface lav_req_if;
   logic               valid;
   logic               ready;
   lav_pkg::coord_type eye_x;
   lav_pkg::coord_type eye_y;
   lav_pkg::coord_type eye_z;
   lav_pkg::coord_type target_x;
   lav_pkg::coord_type target_y;
   lav_pkg::coord_type target_z;

   modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                   input ready);
   modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                 output ready);
endinterface

interface lav_rsp_if;
   logic               valid;
   logic               ready;
   lav_pkg::coord_type right_x;
   lav_pkg::coord_type right_y;
   lav_pkg::coord_type right_z;
   lav_pkg::coord_type up_x;
   lav_pkg::coord_type up_y;
   lav_pkg::coord_type up_z;
   lav_pkg::coord_type back_x;
   lav_pkg::coord_type back_y;
   lav_pkg::coord_type back_z;
   lav_pkg::coord_type shift_x;
   lav_pkg::coord_type shift_y;
   lav_pkg::coord_type shift_z;

   modport source (output valid, right_x, right_y, right_z, up_x, up_y, up_z,
                   back_x, back_y, back_z, shift_x, shift_y, shift_z,
                   input ready);
   modport sink (input valid, right_x, right_y, right_z, up_x, up_y, up_z,
                 back_x, back_y, back_z, shift_x, shift_y, shift_z,
                 output ready);
endinterface

// File: sv/lav_isqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on lav_pkg.
module lav_isqrt #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [lav_pkg::SQ_W-1:0]  in_sq,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [lav_pkg::LEN_W-1:0] out_root,
   output logic [SIDE_W-1:0]         out_side
);
   localparam int SW    = lav_pkg::SQ_W;
   localparam int NSTEP = SW / 2;

   logic [SW-1:0]     rem_ff  [NSTEP];
   logic [SW-1:0]     root_ff [NSTEP];
   logic [SIDE_W-1:0] side_ff [NSTEP];
   logic [NSTEP-1:0]  valid_ff;

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      localparam logic [SW-1:0] STEP_BIT = SW'(1) << (SW - 2 - 2 * k);
      logic [SW-1:0]     rem_prev;
      logic [SW-1:0]     root_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              valid_prev;
      logic [SW-1:0]     trial;
      logic [SW-1:0]     rem_in;
      logic [SW-1:0]     root_in;

      if (k == 0) begin : g_first
         assign rem_prev   = in_sq;
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         trial = root_prev + STEP_BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + STEP_BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NSTEP-1];
   assign out_root  = root_ff[NSTEP-1][lav_pkg::LEN_W-1:0];
   assign out_side  = side_ff[NSTEP-1];

endmodule

// File: sv/lav_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, three lanes over one shared divisor,
// one quotient bit per stage. Depends on lav_pkg.
module lav_div #(
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [2:0][lav_pkg::NUM_W-1:0] in_num,
   input  logic [lav_pkg::LEN_W-1:0]      in_den,
   input  logic [SIDE_W-1:0]              in_side,
   output logic                           out_valid,
   output logic [2:0][lav_pkg::QUO_W-1:0] out_quo,
   output logic [SIDE_W-1:0]              out_side
);
   localparam int NSTEP = lav_pkg::QUO_W;
   localparam int QW    = lav_pkg::QUO_W;
   localparam int NW    = lav_pkg::NUM_W;
   localparam int DW    = lav_pkg::LEN_W;
   localparam int RW    = lav_pkg::LEN_W + 1;

   logic [2:0][NW-1:0] num_ff  [NSTEP];
   logic [2:0][RW-1:0] rem_ff  [NSTEP];
   logic [2:0][QW-1:0] quo_ff  [NSTEP];
   logic [DW-1:0]      den_ff  [NSTEP];
   logic [SIDE_W-1:0]  side_ff [NSTEP];
   logic [NSTEP-1:0]   valid_ff;

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      logic [2:0][NW-1:0] num_prev;
      logic [2:0][RW-1:0] rem_prev;
      logic [2:0][QW-1:0] quo_prev;
      logic [DW-1:0]      den_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic               valid_prev;
      logic [2:0][RW-1:0] rem_in;
      logic [2:0][QW-1:0] quo_in;

      if (k == 0) begin : g_first
         // The dividend's upper bits already sit below the divisor.
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_prev[i] = RW'(in_num[i] >> QW);
         end
         assign num_prev   = in_num;
         assign quo_prev   = '0;
         assign den_prev   = in_den;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign num_prev   = num_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign quo_prev   = quo_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign side_prev  = side_ff[k-1];
         assign valid_prev = valid_ff[k-1];
      end

      always_comb begin
         logic [RW-1:0] shifted;
         for (int i = 0; i < 3; i++) begin
            shifted = {rem_prev[i][RW-2:0], num_prev[i][QW-1-k]};
            if (shifted >= {1'b0, den_prev}) begin
               rem_in[i] = shifted - {1'b0, den_prev};
               quo_in[i] = {quo_prev[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i] = shifted;
               quo_in[i] = {quo_prev[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv) begin
            valid_ff[k] <= valid_prev;
         end
         if (adv) begin
            num_ff[k]  <= num_prev;
            rem_ff[k]  <= rem_in;
            quo_ff[k]  <= quo_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NSTEP-1];
   assign out_quo   = quo_ff[NSTEP-1];
   assign out_side  = side_ff[NSTEP-1];

endmodule

// File: sv/lav_unit.sv
`timescale 1ns / 1ps
// Vector normalizer: prescale, squares, square root and three divides.
// Depends on lav_pkg, lav_isqrt and lav_div.
module lav_unit #(
   parameter int SIDE_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  logic [2:0][lav_pkg::IN_W-1:0]  in_vec,
   input  logic [SIDE_W-1:0]              in_side,
   output logic                           out_valid,
   output logic [2:0][lav_pkg::VEC_W-1:0] out_vec,
   output logic [SIDE_W-1:0]              out_side
);
   localparam int MW = lav_pkg::MAG_W;
   localparam int NM = lav_pkg::NRM_W;
   localparam int PW = lav_pkg::POS_W;

   typedef struct packed {
      logic [SIDE_W-1:0]  side;
      logic [2:0]         neg;
      logic [2:0][NM-1:0] nm;
   } root_side_type;

   typedef struct packed {
      logic [SIDE_W-1:0] side;
      logic [2:0]        neg;
   } div_side_type;

   // stage 1: magnitudes and their maximum
   logic [2:0][MW-1:0] mag_ff, mag_in;
   logic [MW-1:0]      max_ff, max_in;
   logic [2:0]         neg1_ff;
   logic [SIDE_W-1:0]  side1_ff;
   logic               v1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_in[i] = in_vec[i][lav_pkg::IN_W-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
      end
      max_in = mag_in[0];
      if (mag_in[1] > max_in) max_in = mag_in[1];
      if (mag_in[2] > max_in) max_in = mag_in[2];
   end

   // stage 2: shift all three so the largest has its top bit at NRM_TOP
   logic [2:0][NM-1:0] nm2_ff, nm2_in;
   logic [2:0]         neg2_ff;
   logic [SIDE_W-1:0]  side2_ff;
   logic               v2_ff;

   always_comb begin
      logic [PW-1:0] pos;
      logic [MW-1:0] sh;
      pos = '0;
      for (int b = 0; b < MW; b++) begin
         if (max_ff[b]) pos = PW'(b);
      end
      for (int i = 0; i < 3; i++) begin
         if (pos > PW'(lav_pkg::NRM_TOP)) begin
            sh = mag_ff[i] >> (pos - PW'(lav_pkg::NRM_TOP));
         end else begin
            sh = mag_ff[i] << (PW'(lav_pkg::NRM_TOP) - pos);
         end
         nm2_in[i] = sh[NM-1:0];
      end
   end

   // stage 3: squares; stage 4: their sum
   logic [2:0][2*NM-1:0] sq3_ff;
   logic [2:0][NM-1:0]   nm3_ff;
   logic [2:0]           neg3_ff;
   logic [SIDE_W-1:0]    side3_ff;
   logic                 v3_ff;

   logic [lav_pkg::SQ_W-1:0] sum4_ff, sum4_in;
   root_side_type            rs4_ff;
   logic                     v4_ff;

   assign sum4_in = lav_pkg::SQ_W'(sq3_ff[0]) + lav_pkg::SQ_W'(sq3_ff[1])
                  + lav_pkg::SQ_W'(sq3_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         mag_ff   <= mag_in;
         max_ff   <= max_in;
         side1_ff <= in_side;
         for (int i = 0; i < 3; i++) begin
            neg1_ff[i] <= in_vec[i][lav_pkg::IN_W-1];
            sq3_ff[i]  <= nm2_ff[i] * nm2_ff[i];
         end
         nm2_ff      <= nm2_in;
         neg2_ff     <= neg1_ff;
         side2_ff    <= side1_ff;
         nm3_ff      <= nm2_ff;
         neg3_ff     <= neg2_ff;
         side3_ff    <= side2_ff;
         sum4_ff     <= sum4_in;
         rs4_ff.side <= side3_ff;
         rs4_ff.neg  <= neg3_ff;
         rs4_ff.nm   <= nm3_ff;
      end
   end

   // length
   logic                      root_valid;
   logic [lav_pkg::LEN_W-1:0] root_len;
   root_side_type             root_side;

   lav_isqrt #(.SIDE_W($bits(root_side_type))) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v4_ff),
      .in_sq    (sum4_ff),
      .in_side  (rs4_ff),
      .out_valid(root_valid),
      .out_root (root_len),
      .out_side (root_side)
   );

   // round half up: add half the divisor to the scaled magnitude
   logic [2:0][lav_pkg::NUM_W-1:0] num;
   div_side_type                   ds_in, ds_out;
   logic [2:0][lav_pkg::QUO_W-1:0] quo;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = lav_pkg::NUM_W'({root_side.nm[i], lav_pkg::FRAC_W'(0)})
                + lav_pkg::NUM_W'(root_len >> 1);
      end
      ds_in.side = root_side.side;
      ds_in.neg  = root_side.neg;
   end

   lav_div #(.SIDE_W($bits(div_side_type))) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (root_valid),
      .in_num   (num),
      .in_den   (root_len),
      .in_side  (ds_in),
      .out_valid(out_valid),
      .out_quo  (quo),
      .out_side (ds_out)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_vec[i] = ds_out.neg[i] ? -lav_pkg::VEC_W'(quo[i]) : lav_pkg::VEC_W'(quo[i]);
      end
   end
   assign out_side = ds_out.side;

endmodule

// File: sv/look_at_view_matrix_core.sv
`timescale 1ns / 1ps
// Top level of the look-at view matrix core.
// Depends on lav_pkg, lav_if and lav_unit.
//
// Takes an eye point and a target point (signed Q16.16) and returns the
// twelve non-constant entries of a right-handed look-at view matrix with
// world up (0,1,0): right, recomputed up, negated forward, and the three
// saturated translation terms. Forward falls back to (0,0,-1) when eye and
// target lie within 0.0001 of each other; right stays unnormalized (and is
// zero when looking straight up or down) when it is that short. One word
// is accepted every cycle while the response is not stalled, and each
// word yields exactly one response word, in order. The path holds 116
// register stages, most of them in the two vector normalizers (54 stages
// each, dominated by a one-bit-per-stage square root and divider). A
// stalled response holds the whole pipeline in place and also holds off
// new requests; while the output register is empty the pipeline keeps
// advancing even if the receiver is not ready.
module look_at_view_matrix_core (
   input logic       clock,
   input logic       reset,
   lav_req_if.sink   req_port,
   lav_rsp_if.source rsp_port
);
   localparam int CW = lav_pkg::COORD_W;
   localparam int VW = lav_pkg::VEC_W;

   logic adv;
   logic out_valid_ff;

   // advance everything whenever the output register is free or drained
   assign adv            = !out_valid_ff || rsp_port.ready;
   assign req_port.ready = adv;

   // stage 0: hold eye, form target minus eye
   logic [2:0][CW-1:0]            req_eye, req_tgt;
   logic                          s0_valid_ff;
   logic [2:0][CW-1:0]            s0_eye_ff;
   logic [2:0][lav_pkg::IN_W-1:0] s0_diff_ff, s0_diff_in;

   assign req_eye = {req_port.eye_z, req_port.eye_y, req_port.eye_x};
   assign req_tgt = {req_port.target_z, req_port.target_y, req_port.target_x};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s0_diff_in[i] = lav_pkg::IN_W'($signed(req_tgt[i]))
                       - lav_pkg::IN_W'($signed(req_eye[i]));
      end
   end

   // short forward: every component tiny and squared length at most 42
   lav_pkg::fwd_side_type fwd_side_in, fwd_side_out;
   logic                  fwd_valid;
   logic [2:0][VW-1:0]    fwd_vec;

   always_comb begin
      logic                       near;
      logic [lav_pkg::NEAR_W-1:0] am;
      logic [7:0]                 sq_sum;
      near   = 1'b1;
      sq_sum = '0;
      for (int i = 0; i < 3; i++) begin
         near = near
              && ($signed(s0_diff_ff[i]) >= -lav_pkg::IN_W'(lav_pkg::NEAR_MAX))
              && ($signed(s0_diff_ff[i]) <= lav_pkg::IN_W'(lav_pkg::NEAR_MAX));
         am = s0_diff_ff[i][lav_pkg::IN_W-1] ? lav_pkg::NEAR_W'(-s0_diff_ff[i])
                                             : lav_pkg::NEAR_W'(s0_diff_ff[i]);
         sq_sum = sq_sum + 8'(am) * 8'(am);
      end
      fwd_side_in.short_fwd = near && (sq_sum <= 8'(lav_pkg::SHORT_SQ_MAX));
      fwd_side_in.eye       = s0_eye_ff;
   end

   lav_unit #(.SIDE_W($bits(lav_pkg::fwd_side_type))) u_fwd (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s0_valid_ff),
      .in_vec   (s0_diff_ff),
      .in_side  (fwd_side_in),
      .out_valid(fwd_valid),
      .out_vec  (fwd_vec),
      .out_side (fwd_side_out)
   );

   // stage t1: pick forward
   logic                t1_valid_ff;
   lav_pkg::vec_type    t1_f_ff [3];
   lav_pkg::vec_type    t1_f_in [3];
   logic [2:0][CW-1:0]  t1_eye_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t1_f_in[i] = fwd_side_out.short_fwd ? VW'(0) : $signed(fwd_vec[i]);
      end
      if (fwd_side_out.short_fwd) t1_f_in[2] = -VW'(lav_pkg::ONE_Q);
   end

   // stage t2: squares for the short-right test
   logic                               t2_valid_ff;
   lav_pkg::vec_type                   t2_f_ff [3];
   logic [2:0][CW-1:0]                 t2_eye_ff;
   logic signed [lav_pkg::PROD_W-1:0]  t2_fsq0_ff, t2_fsq2_ff;

   // right before normalizing is (-fz, 0, fx)
   lav_pkg::rgt_side_type          rgt_side_in, rgt_side_out;
   logic [2:0][lav_pkg::IN_W-1:0]  rgt_raw;
   logic                           rgt_valid;
   logic [2:0][VW-1:0]             rgt_vec;

   always_comb begin
      rgt_raw[0]       = lav_pkg::IN_W'(-t2_f_ff[2]);
      rgt_raw[1]       = '0;
      rgt_raw[2]       = lav_pkg::IN_W'(t2_f_ff[0]);
      rgt_side_in.norm = ((lav_pkg::PROD_W + 1)'(t2_fsq0_ff)
                        + (lav_pkg::PROD_W + 1)'(t2_fsq2_ff))
                       > (lav_pkg::PROD_W + 1)'(lav_pkg::SHORT_SQ_MAX);
      for (int i = 0; i < 3; i++) begin
         rgt_side_in.fwd[i] = t2_f_ff[i];
      end
      rgt_side_in.eye = t2_eye_ff;
   end

   lav_unit #(.SIDE_W($bits(lav_pkg::rgt_side_type))) u_rgt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (t2_valid_ff),
      .in_vec   (rgt_raw),
      .in_side  (rgt_side_in),
      .out_valid(rgt_valid),
      .out_vec  (rgt_vec),
      .out_side (rgt_side_out)
   );

   // stage t3: pick right (its y is always zero)
   logic               t3_valid_ff;
   lav_pkg::vec_type   t3_r_ff [3];
   lav_pkg::vec_type   t3_r_in [3];
   lav_pkg::vec_type   t3_f_ff [3];
   logic [2:0][CW-1:0] t3_eye_ff;

   always_comb begin
      if (rgt_side_out.norm) begin
         for (int i = 0; i < 3; i++) t3_r_in[i] = $signed(rgt_vec[i]);
      end else begin
         t3_r_in[0] = -$signed(rgt_side_out.fwd[2]);
         t3_r_in[1] = '0;
         t3_r_in[2] = $signed(rgt_side_out.fwd[0]);
      end
   end

   // stage t4: products for the cross product and two dot products
   logic                              t4_valid_ff;
   logic signed [lav_pkg::PROD_W-1:0] t4_r2f1_ff, t4_r2f0_ff, t4_r0f2_ff, t4_r0f1_ff;
   logic signed [lav_pkg::RE_W-1:0]   t4_re0_ff, t4_re2_ff;
   logic signed [lav_pkg::RE_W-1:0]   t4_fe_ff [3];
   lav_pkg::vec_type                  t4_r_ff [3];
   lav_pkg::vec_type                  t4_f_ff [3];
   logic [2:0][CW-1:0]                t4_eye_ff;

   // stage t5: round up vector, finish right and forward translations
   logic                       t5_valid_ff;
   lav_pkg::uvec_type          t5_u_ff [3];
   lav_pkg::coord_type         t5_shx_ff, t5_shz_ff;
   lav_pkg::vec_type           t5_r_ff [3];
   lav_pkg::vec_type           t5_f_ff [3];
   logic [2:0][CW-1:0]         t5_eye_ff;
   logic signed [lav_pkg::CRS_W-1:0] crs_x, crs_y, crs_z;
   logic signed [lav_pkg::DOT_W-1:0] dot_r, dot_f;

   always_comb begin
      crs_x = -lav_pkg::CRS_W'(t4_r2f1_ff);
      crs_y = lav_pkg::CRS_W'(t4_r2f0_ff) - lav_pkg::CRS_W'(t4_r0f2_ff);
      crs_z = lav_pkg::CRS_W'(t4_r0f1_ff);
      dot_r = -(lav_pkg::DOT_W'(t4_re0_ff) + lav_pkg::DOT_W'(t4_re2_ff));
      dot_f = lav_pkg::DOT_W'(t4_fe_ff[0]) + lav_pkg::DOT_W'(t4_fe_ff[1])
            + lav_pkg::DOT_W'(t4_fe_ff[2]);
   end

   // stage t6: up times eye
   logic                            t6_valid_ff;
   logic signed [lav_pkg::UE_W-1:0] t6_ue_ff [3];
   lav_pkg::uvec_type               t6_u_ff [3];
   lav_pkg::coord_type              t6_shx_ff, t6_shz_ff;
   lav_pkg::vec_type                t6_r_ff [3];
   lav_pkg::vec_type                t6_f_ff [3];
   logic signed [lav_pkg::DOT_W-1:0] dot_u;

   assign dot_u = -(lav_pkg::DOT_W'(t6_ue_ff[0]) + lav_pkg::DOT_W'(t6_ue_ff[1])
                  + lav_pkg::DOT_W'(t6_ue_ff[2]));

   // output register
   lav_pkg::coord_type out_right_ff [3];
   lav_pkg::coord_type out_up_ff [3];
   lav_pkg::coord_type out_back_ff [3];
   lav_pkg::coord_type out_shift_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         t1_valid_ff  <= 1'b0;
         t2_valid_ff  <= 1'b0;
         t3_valid_ff  <= 1'b0;
         t4_valid_ff  <= 1'b0;
         t5_valid_ff  <= 1'b0;
         t6_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff  <= req_port.valid;
         t1_valid_ff  <= fwd_valid;
         t2_valid_ff  <= t1_valid_ff;
         t3_valid_ff  <= rgt_valid;
         t4_valid_ff  <= t3_valid_ff;
         t5_valid_ff  <= t4_valid_ff;
         t6_valid_ff  <= t5_valid_ff;
         out_valid_ff <= t6_valid_ff;
      end
      if (adv) begin
         s0_eye_ff  <= req_eye;
         s0_diff_ff <= s0_diff_in;

         t1_f_ff    <= t1_f_in;
         t1_eye_ff  <= fwd_side_out.eye;

         t2_f_ff    <= t1_f_ff;
         t2_eye_ff  <= t1_eye_ff;
         t2_fsq0_ff <= t1_f_ff[0] * t1_f_ff[0];
         t2_fsq2_ff <= t1_f_ff[2] * t1_f_ff[2];

         t3_r_ff    <= t3_r_in;
         for (int i = 0; i < 3; i++) t3_f_ff[i] <= $signed(rgt_side_out.fwd[i]);
         t3_eye_ff  <= rgt_side_out.eye;

         t4_r2f1_ff <= t3_r_ff[2] * t3_f_ff[1];
         t4_r2f0_ff <= t3_r_ff[2] * t3_f_ff[0];
         t4_r0f2_ff <= t3_r_ff[0] * t3_f_ff[2];
         t4_r0f1_ff <= t3_r_ff[0] * t3_f_ff[1];
         t4_re0_ff  <= t3_r_ff[0] * $signed(t3_eye_ff[0]);
         t4_re2_ff  <= t3_r_ff[2] * $signed(t3_eye_ff[2]);
         for (int i = 0; i < 3; i++) t4_fe_ff[i] <= t3_f_ff[i] * $signed(t3_eye_ff[i]);
         t4_r_ff    <= t3_r_ff;
         t4_f_ff    <= t3_f_ff;
         t4_eye_ff  <= t3_eye_ff;

         t5_u_ff[0] <= lav_pkg::round_cross(crs_x);
         t5_u_ff[1] <= lav_pkg::round_cross(crs_y);
         t5_u_ff[2] <= lav_pkg::round_cross(crs_z);
         t5_shx_ff  <= lav_pkg::round_sat(dot_r);
         t5_shz_ff  <= lav_pkg::round_sat(dot_f);
         t5_r_ff    <= t4_r_ff;
         t5_f_ff    <= t4_f_ff;
         t5_eye_ff  <= t4_eye_ff;

         for (int i = 0; i < 3; i++) t6_ue_ff[i] <= t5_u_ff[i] * $signed(t5_eye_ff[i]);
         t6_u_ff    <= t5_u_ff;
         t6_shx_ff  <= t5_shx_ff;
         t6_shz_ff  <= t5_shz_ff;
         t6_r_ff    <= t5_r_ff;
         t6_f_ff    <= t5_f_ff;

         for (int i = 0; i < 3; i++) begin
            out_right_ff[i] <= CW'(t6_r_ff[i]);
            out_up_ff[i]    <= CW'(t6_u_ff[i]);
            out_back_ff[i]  <= CW'(-t6_f_ff[i]);
         end
         out_shift_ff[0] <= t6_shx_ff;
         out_shift_ff[1] <= lav_pkg::round_sat(dot_u);
         out_shift_ff[2] <= t6_shz_ff;
      end
   end

   assign rsp_port.valid   = out_valid_ff;
   assign rsp_port.right_x = out_right_ff[0];
   assign rsp_port.right_y = out_right_ff[1];
   assign rsp_port.right_z = out_right_ff[2];
   assign rsp_port.up_x    = out_up_ff[0];
   assign rsp_port.up_y    = out_up_ff[1];
   assign rsp_port.up_z    = out_up_ff[2];
   assign rsp_port.back_x  = out_back_ff[0];
   assign rsp_port.back_y  = out_back_ff[1];
   assign rsp_port.back_z  = out_back_ff[2];
   assign rsp_port.shift_x = out_shift_ff[0];
   assign rsp_port.shift_y = out_shift_ff[1];
   assign rsp_port.shift_z = out_shift_ff[2];

   // a stalled pipeline holds every stage's occupancy
   logic [7:0] pipe_valid;
   assign pipe_valid = {s0_valid_ff, t1_valid_ff, t2_valid_ff, t3_valid_ff,
                        t4_valid_ff, t5_valid_ff, t6_valid_ff, out_valid_ff};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(pipe_valid))
      else $error("pipeline occupancy changed during a stall");

   a_accept_enter: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> s0_valid_ff)
      else $error("accepted request did not enter stage 0");

   a_fwd_range: assert property (@(posedge clock) disable iff (reset)
      t1_valid_ff |-> ((t1_f_ff[0] <= VW'(lav_pkg::ONE_Q + 1))
                    && (t1_f_ff[0] >= -VW'(lav_pkg::ONE_Q + 1))
                    && (t1_f_ff[2] <= VW'(lav_pkg::ONE_Q + 1))
                    && (t1_f_ff[2] >= -VW'(lav_pkg::ONE_Q + 1))))
      else $error("forward component outside unit range");

   a_right_flat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_right_ff[1] == '0))
      else $error("right vector has a nonzero y");

endmodule

// File: test/look_at_view_matrix_core_tb.sv
`timescale 1ns / 1ps
// Testbench for look_at_view_matrix_core: random and directed point pairs,
// predicted in Q16.16 fixed point and compared word by word.
// Depends on lav_pkg, lav_if and the core RTL.
module look_at_view_matrix_core_tb;

   typedef struct {
      lav_pkg::coord_type rx, ry, rz, ux, uy, uz, bx, by, bz, sx, sy, sz;
   } matrix_word_type;

   // Magnitude of a signed 64-bit value.
   function automatic longint unsigned abs64(input longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   // Round half up from Q32 to Q16.16 (floor after adding a half).
   function automatic longint round_half(input longint v);
      longint t;
      t = v + 32768;
      return t >>> 16;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scale a vector to unit length in Q16.16.
   function automatic void unit_vector(input longint a[3], output longint o[3]);
      longint unsigned m[3], mx, sq, len;
      mx = 0;
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = abs64(a[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o = '{0, 0, 0};
         return;
      end
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) sq += m[i] * m[i];
      len = int_sqrt(sq);
      for (int i = 0; i < 3; i++) begin
         longint q;
         q = ((m[i] << 16) + (len >> 1)) / len;
         o[i] = a[i] < 0 ? -q : q;
      end
   endfunction

   function automatic void predict_view(input lav_pkg::coord_type p[6],
                                        output matrix_word_type w);
      longint e[3], d[3], f[3], r[3], t[3], u[3];
      longint unsigned mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         e[i] = p[i];
         d[i] = longint'(p[i + 3]) - e[i];
         if (abs64(d[i]) > mx) mx = abs64(d[i]);
      end
      if (mx < 8 && d[0] * d[0] + d[1] * d[1] + d[2] * d[2] <= lav_pkg::SHORT_SQ_MAX)
         f = '{0, 0, -65536};
      else
         unit_vector(d, f);
      r = '{-f[2], 0, f[0]};
      if (f[0] * f[0] + f[2] * f[2] > lav_pkg::SHORT_SQ_MAX) begin
         unit_vector(r, t);
         r = t;
      end
      u[0] = round_half(r[1] * f[2] - r[2] * f[1]);
      u[1] = round_half(r[2] * f[0] - r[0] * f[2]);
      u[2] = round_half(r[0] * f[1] - r[1] * f[0]);
      w.rx = r[0]; w.ry = r[1]; w.rz = r[2];
      w.ux = u[0]; w.uy = u[1]; w.uz = u[2];
      w.bx = -f[0]; w.by = -f[1]; w.bz = -f[2];
      w.sx = clamp32(round_half(-(r[0] * e[0] + r[1] * e[1] + r[2] * e[2])));
      w.sy = clamp32(round_half(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2])));
      w.sz = clamp32(round_half(f[0] * e[0] + f[1] * e[1] + f[2] * e[2]));
   endfunction

   class view_scoreboard;
      matrix_word_type pending[$];
      int errors = 0;
      int matched = 0;

      function void note_request(lav_pkg::coord_type p[6]);
         matrix_word_type w;
         predict_view(p, w);
         pending.push_back(w);
      endfunction

      function void cmp(string name, lav_pkg::coord_type exp_v,
                        lav_pkg::coord_type act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s expected %0d (%h) actual %0d (%h)",
                     $time, name, exp_v, exp_v, act_v, act_v);
         end
      endfunction

      function void check_response(matrix_word_type a);
         matrix_word_type x;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected response word, expected none actual %h",
                     $time, a.rx);
            return;
         end
         x = pending.pop_front();
         matched++;
         cmp("right_x", x.rx, a.rx); cmp("right_y", x.ry, a.ry);
         cmp("right_z", x.rz, a.rz); cmp("up_x", x.ux, a.ux);
         cmp("up_y", x.uy, a.uy);    cmp("up_z", x.uz, a.uz);
         cmp("back_x", x.bx, a.bx);  cmp("back_y", x.by, a.by);
         cmp("back_z", x.bz, a.bz);  cmp("shift_x", x.sx, a.sx);
         cmp("shift_y", x.sy, a.sy); cmp("shift_z", x.sz, a.sz);
      endfunction
   endclass

   localparam int LATENCY = 116;
   localparam int RANDOM_ITEMS = 1330;
   localparam int LONG_HOLD = 400;

   logic clock;
   logic reset;
   lav_req_if req_port ();
   lav_rsp_if rsp_port ();
   view_scoreboard board;
   bit stim_done;
   int sent;

   look_at_view_matrix_core dut (
      .clock(clock),
      .reset(reset),
      .req_port(req_port.sink),
      .rsp_port(rsp_port.source)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Hard limit well above the slowest legal run.
   initial begin
      #4000000;
      $display("timeout with %0d words outstanding", board.pending.size());
      $display("simulation failed");
      $finish;
   end

   // Random 32-bit word with bias toward extremes and small values.
   function automatic lav_pkg::coord_type rand_coord();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff - $urandom_range(0, 3);
         1: return 32'sh80000000 + $urandom_range(0, 3);
         2: return $signed($urandom_range(0, 1023)) - 512;
         3: return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
         default: return $urandom;
      endcase
   endfunction

   // Present one word, hold it until accepted, then drop valid for a random gap unless the gap is zero.
   task automatic send_pair(input lav_pkg::coord_type p[6]);
      int gap;
      req_port.valid <= 1'b1;
      req_port.eye_x <= p[0]; req_port.eye_y <= p[1]; req_port.eye_z <= p[2];
      req_port.target_x <= p[3]; req_port.target_y <= p[4];
      req_port.target_z <= p[5];
      do @(posedge clock); while (!req_port.ready);
      board.note_request(p);
      sent++;
      gap = $urandom_range(0, 4);
      if (sent % 200 > 150) gap = 0;
      if (gap > 0) begin
         req_port.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random();
      lav_pkg::coord_type p[6];
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 6; i++) p[i] = rand_coord();
      case (mode)
         0: for (int i = 0; i < 3; i++)                 // nearly equal points
            p[i + 3] = p[i] + $signed($urandom_range(0, 8)) - 4;
         1: begin                                       // straight up or down
            p[3] = p[0] + $signed($urandom_range(0, 6)) - 3;
            p[5] = p[2] + $signed($urandom_range(0, 6)) - 3;
         end
         default: ;
      endcase
      send_pair(p);
   endtask

   // Receiver: random stall per word, with stall-free stretches, plus one long hold-off.
   initial begin
      int stall;
      int taken;
      matrix_word_type a;
      taken = 0;
      rsp_port.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(0, 4);
         if ((taken / 150) % 2 == 1) stall = 0;
         if (taken == 300) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp_port.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_port.ready <= 1'b1;
         do @(posedge clock); while (!rsp_port.valid);
         a.rx = rsp_port.right_x; a.ry = rsp_port.right_y; a.rz = rsp_port.right_z;
         a.ux = rsp_port.up_x;    a.uy = rsp_port.up_y;    a.uz = rsp_port.up_z;
         a.bx = rsp_port.back_x;  a.by = rsp_port.back_y;  a.bz = rsp_port.back_z;
         a.sx = rsp_port.shift_x; a.sy = rsp_port.shift_y; a.sz = rsp_port.shift_z;
         board.check_response(a);
         taken++;
      end
   end

   initial begin
      lav_pkg::coord_type p[6];
      int wait_cycles;
      board = new();
      sent = 0;
      reset <= 1'b1;
      req_port.valid <= 1'b0;
      req_port.eye_x <= '0; req_port.eye_y <= '0; req_port.eye_z <= '0;
      req_port.target_x <= '0; req_port.target_y <= '0; req_port.target_z <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coincident points, short offsets, poles, extremes.
      p = '{0, 0, 0, 0, 0, 0};                        send_pair(p);
      p = '{0, 0, 0, 6, 1, 1};                        send_pair(p);
      p = '{0, 0, 0, 4, 4, 4};                        send_pair(p);
      p = '{0, 0, 0, 7, 0, 0};                        send_pair(p);
      p = '{0, 0, 0, 8, 0, 0};                        send_pair(p);
      p = '{0, 0, 0, 0, 65536, 0};                    send_pair(p);
      p = '{0, 0, 0, 0, -65536, 0};                   send_pair(p);
      p = '{0, 0, 0, 3, 65536, 6};                    send_pair(p);
      p = '{0, 0, 0, 4, 65536, 6};                    send_pair(p);
      p = '{0, 0, 65536, 0, 0, 0};                    send_pair(p);
      p = '{65536, 2 * 65536, 3 * 65536, 0, 0, 0};    send_pair(p);
      p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'sh80000000, 32'sh80000000}; send_pair(p);
      p = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}; send_pair(p);
      p = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000,
            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}; send_pair(p);
      p = '{32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 5, 32'sh80000000};
      send_pair(p);
      p = '{32'sh80000000, 0, 32'sh7fffffff, 32'sh80000001, 0, 32'sh7fffffff};
      send_pair(p);
      p = '{-1, -1, -1, -1, -1, -1};                  send_pair(p);
      p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0};
      send_pair(p);

      for (int n = 0; n < RANDOM_ITEMS; n++) send_random();
      req_port.valid <= 1'b0;

      // Drain, then let the pipeline settle.
      wait_cycles = 0;
      while (board.pending.size() != 0 && wait_cycles < 20 * LATENCY + LONG_HOLD) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (2 * LATENCY) @(posedge clock);
      $display("%0d point pairs sent, %0d matrices checked, including degenerate",
               sent, board.matched);
      $display("forward/right fallbacks, saturated translations and a long stall.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches, %0d words missing", board.errors,
                  board.pending.size());
         $display("simulation failed");
      end
      $finish;
   end
endmodule
